/* rtl/packet_ring_buffer_manager_core_defines.svh */
// Assertion macros shared by the packet ring buffer manager RTL.
`ifndef PACKET_RING_BUFFER_MANAGER_CORE_DEFINES_SVH
`define PACKET_RING_BUFFER_MANAGER_CORE_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define PRBM_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define PRBM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/prbm_pkg.sv */
// Shared constants, codes and microcode types of the packet ring buffer manager.
package prbm_pkg;

   localparam int KIND_W   = 3;
   localparam int LEN_W    = 16;
   localparam int OFF_W    = 10;
   localparam int BYTE_W   = 8;
   localparam int RING_W   = 11;
   localparam int POFF_W   = 11;
   localparam int PEAK_W   = 11;

   localparam int MEM_BYTES = 1024;
   localparam int MEM_AW    = $clog2(MEM_BYTES);
   localparam int RING_MAX  = MEM_BYTES & ~3;
   localparam int RING_MIN  = 8;
   localparam int IDX_W     = $clog2(RING_MAX);
   localparam int SLOT_W    = LEN_W + 2;

   localparam logic [LEN_W-1:0]  MAX_PACKET_LEN = LEN_W'(65280);
   localparam logic [BYTE_W-1:0] PAD_MARK       = 8'hFF;
   localparam int                HDR_BYTES      = 4;

   typedef enum logic [KIND_W-1:0] {
      KIND_ALLOC  = 3'd0,
      KIND_COMMIT = 3'd1,
      KIND_CLAIM  = 3'd2,
      KIND_FREE   = 3'd3,
      KIND_DWRITE = 3'd4,
      KIND_DREAD  = 3'd5
   } kind_type;

   localparam int STEP_W = 4;

   typedef enum logic [STEP_W-1:0] {
      STEP_ALLOC_EVAL   = 4'd0,
      STEP_ALLOC_PAD    = 4'd1,
      STEP_COMMIT_HI    = 4'd2,
      STEP_COMMIT_LO    = 4'd3,
      STEP_CLAIM_RD     = 4'd4,
      STEP_CLAIM_HDR    = 4'd5,
      STEP_CLAIM_LO     = 4'd6,
      STEP_CLAIM_WRAP   = 4'd7,
      STEP_CLAIM_WRAPHI = 4'd8,
      STEP_FREE_CALC    = 4'd9,
      STEP_FREE_RD      = 4'd10,
      STEP_FREE_SET     = 4'd11,
      STEP_DWRITE       = 4'd12,
      STEP_DREAD        = 4'd13,
      STEP_DREAD_OUT    = 4'd14,
      STEP_FIN          = 4'd15
   } step_type;

   typedef enum logic [2:0] {
      COND_ALWAYS   = 3'd0,
      COND_FLAG     = 3'd1,
      COND_LEN_NZ   = 3'd2,
      COND_RD_EQ_WR = 3'd3,
      COND_IS_PAD   = 3'd4
   } cond_sel_type;

   typedef enum logic [1:0] {
      MEM_IDLE  = 2'd0,
      MEM_READ  = 2'd1,
      MEM_WRITE = 2'd2
   } mem_op_type;

   typedef enum logic [2:0] {
      ADDR_WR      = 3'd0,
      ADDR_WR_NEXT = 3'd1,
      ADDR_RD      = 3'd2,
      ADDR_RD_NEXT = 3'd3,
      ADDR_OFF     = 3'd4,
      ADDR_NXT     = 3'd5
   } addr_sel_type;

   typedef enum logic [1:0] {
      WDATA_PAD    = 2'd0,
      WDATA_LEN_HI = 2'd1,
      WDATA_LEN_LO = 2'd2,
      WDATA_DIN    = 2'd3
   } wdata_sel_type;

   typedef enum logic [3:0] {
      ACT_NONE       = 4'd0,
      ACT_ALLOC_EVAL = 4'd1,
      ACT_WR_ZERO    = 4'd2,
      ACT_WR_NEXT    = 4'd3,
      ACT_PEAK       = 4'd4,
      ACT_CLAIM_HDR  = 4'd5,
      ACT_GRANT_HI   = 4'd6,
      ACT_GRANT_LO   = 4'd7,
      ACT_NXT_CALC   = 4'd8,
      ACT_RD_FREE    = 4'd9,
      ACT_DOUT       = 4'd10
   } action_type;

   typedef struct packed {
      cond_sel_type  cond_sel;
      logic          gated;
      logic          branch;
      step_type      target;
      mem_op_type    mem_op;
      addr_sel_type  addr_sel;
      wdata_sel_type wdata_sel;
      action_type    action;
      logic          done;
   } ctl_word_type;

   typedef struct packed {
      logic flag;
      logic len_nz;
      logic rd_eq_wr;
      logic is_pad;
   } seq_cond_type;

   typedef struct packed {
      logic go;
      logic exec;
      logic finish;
   } seq_ctl_type;

   // Start of the slot after a packet of len bytes at idx; wraps to zero at the ring end.
   function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0]  idx,
                                                  input logic [LEN_W-1:0]  len,
                                                  input logic [RING_W-1:0] ring);
      logic [SLOT_W-1:0] sum;
      sum = SLOT_W'(idx) + SLOT_W'(len) + SLOT_W'(HDR_BYTES + 3);
      sum[1:0] = 2'b00;
      return (sum >= SLOT_W'(ring)) ? '0 : sum[IDX_W-1:0];
   endfunction

endpackage

/* rtl/prbm_if.sv */
// Request, response and register-write channel interfaces of the ring buffer manager.
interface prbm_req_if import prbm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [LEN_W-1:0]  length;
   logic [OFF_W-1:0]  offset;
   logic [BYTE_W-1:0] data_in;

   modport source (output valid, kind, length, offset, data_in, input ready);
   modport sink   (input valid, kind, length, offset, data_in, output ready);
endinterface

interface prbm_rsp_if import prbm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              status;
   logic [LEN_W-1:0]  granted_length;
   logic [POFF_W-1:0] packet_offset;
   logic [BYTE_W-1:0] data_out;
   logic [PEAK_W-1:0] peak_occupancy;

   modport source (output valid, status, granted_length, packet_offset, data_out,
                   peak_occupancy, input ready);
   modport sink   (input valid, status, granted_length, packet_offset, data_out,
                   peak_occupancy, output ready);
endinterface

interface prbm_csr_if import prbm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [RING_W-1:0] ring_bytes;

   modport source (output valid, ring_bytes, input ready);
   modport sink   (input valid, ring_bytes, output ready);
endinterface

/* rtl/prbm_ram.sv */
// Generic single-port RAM with registered read data.
module prbm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/prbm_sequencer.sv */
// Microcode sequencer: step counter, control store and conditional branching.
module prbm_sequencer import prbm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [KIND_W-1:0] kind,
   input  seq_cond_type      cond,
   input  logic              out_free,
   output ctl_word_type      cw,
   output seq_ctl_type       ctl,
   output logic              busy
);

   step_type pc_ff, pc_in;
   logic     busy_ff, busy_in;
   logic     cond_hit;

   function automatic ctl_word_type ucode(input step_type s);
      ctl_word_type w;
      w = '{cond_sel: COND_ALWAYS, gated: 1'b0, branch: 1'b0, target: STEP_FIN,
            mem_op: MEM_IDLE, addr_sel: ADDR_WR, wdata_sel: WDATA_PAD,
            action: ACT_NONE, done: 1'b0};
      case (s)
         STEP_ALLOC_EVAL: begin
            w.action = ACT_ALLOC_EVAL;
         end
         STEP_ALLOC_PAD: begin
            w.cond_sel  = COND_FLAG;
            w.gated     = 1'b1;
            w.mem_op    = MEM_WRITE;
            w.addr_sel  = ADDR_WR;
            w.wdata_sel = WDATA_PAD;
            w.action    = ACT_WR_ZERO;
            w.done      = 1'b1;
         end
         STEP_COMMIT_HI: begin
            w.cond_sel  = COND_LEN_NZ;
            w.gated     = 1'b1;
            w.mem_op    = MEM_WRITE;
            w.addr_sel  = ADDR_WR;
            w.wdata_sel = WDATA_LEN_HI;
         end
         STEP_COMMIT_LO: begin
            w.cond_sel  = COND_LEN_NZ;
            w.gated     = 1'b1;
            w.mem_op    = MEM_WRITE;
            w.addr_sel  = ADDR_WR_NEXT;
            w.wdata_sel = WDATA_LEN_LO;
            w.action    = ACT_WR_NEXT;
            w.done      = 1'b1;
         end
         STEP_CLAIM_RD: begin
            w.cond_sel = COND_RD_EQ_WR;
            w.branch   = 1'b1;
            w.target   = STEP_FIN;
            w.mem_op   = MEM_READ;
            w.addr_sel = ADDR_RD;
            w.action   = ACT_PEAK;
         end
         STEP_CLAIM_HDR: begin
            w.cond_sel = COND_IS_PAD;
            w.branch   = 1'b1;
            w.target   = STEP_CLAIM_WRAP;
            w.mem_op   = MEM_READ;
            w.addr_sel = ADDR_RD_NEXT;
            w.action   = ACT_CLAIM_HDR;
         end
         STEP_CLAIM_LO: begin
            w.action = ACT_GRANT_LO;
            w.done   = 1'b1;
         end
         STEP_CLAIM_WRAP: begin
            w.cond_sel = COND_RD_EQ_WR;
            w.branch   = 1'b1;
            w.target   = STEP_FIN;
            w.mem_op   = MEM_READ;
            w.addr_sel = ADDR_RD;
         end
         STEP_CLAIM_WRAPHI: begin
            w.branch   = 1'b1;
            w.target   = STEP_CLAIM_LO;
            w.mem_op   = MEM_READ;
            w.addr_sel = ADDR_RD_NEXT;
            w.action   = ACT_GRANT_HI;
         end
         STEP_FREE_CALC: begin
            w.action = ACT_NXT_CALC;
         end
         STEP_FREE_RD: begin
            w.mem_op   = MEM_READ;
            w.addr_sel = ADDR_NXT;
         end
         STEP_FREE_SET: begin
            w.action = ACT_RD_FREE;
            w.done   = 1'b1;
         end
         STEP_DWRITE: begin
            w.mem_op    = MEM_WRITE;
            w.addr_sel  = ADDR_OFF;
            w.wdata_sel = WDATA_DIN;
            w.done      = 1'b1;
         end
         STEP_DREAD: begin
            w.mem_op   = MEM_READ;
            w.addr_sel = ADDR_OFF;
         end
         STEP_DREAD_OUT: begin
            w.action = ACT_DOUT;
            w.done   = 1'b1;
         end
         STEP_FIN: begin
            w.done = 1'b1;
         end
         default: begin
            w.done = 1'b1;
         end
      endcase
      return w;
   endfunction

   function automatic step_type dispatch(input logic [KIND_W-1:0] k);
      step_type s;
      case (kind_type'(k))
         KIND_ALLOC:  s = STEP_ALLOC_EVAL;
         KIND_COMMIT: s = STEP_COMMIT_HI;
         KIND_CLAIM:  s = STEP_CLAIM_RD;
         KIND_FREE:   s = STEP_FREE_CALC;
         KIND_DWRITE: s = STEP_DWRITE;
         KIND_DREAD:  s = STEP_DREAD;
         default:     s = STEP_FIN;
      endcase
      return s;
   endfunction

   assign cw = ucode(pc_ff);

   always_comb begin
      case (cw.cond_sel)
         COND_ALWAYS:   cond_hit = 1'b1;
         COND_FLAG:     cond_hit = cond.flag;
         COND_LEN_NZ:   cond_hit = cond.len_nz;
         COND_RD_EQ_WR: cond_hit = cond.rd_eq_wr;
         COND_IS_PAD:   cond_hit = cond.is_pad;
         default:       cond_hit = 1'b0;
      endcase
   end

   // A final step waits until the output register can take its result.
   always_comb begin
      ctl.go     = busy_ff && (!cw.done || out_free);
      ctl.exec   = ctl.go && (!cw.gated || cond_hit);
      ctl.finish = ctl.go && cw.done;
   end

   always_comb begin
      pc_in   = pc_ff;
      busy_in = busy_ff;
      if (start) begin
         pc_in   = dispatch(kind);
         busy_in = 1'b1;
      end else if (ctl.go) begin
         if (cw.done) begin
            busy_in = 1'b0;
         end else if (cw.branch && cond_hit) begin
            pc_in = cw.target;
         end else begin
            pc_in = step_type'(pc_ff + STEP_W'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= STEP_FIN;
         busy_ff <= 1'b0;
      end else begin
         pc_ff   <= pc_in;
         busy_ff <= busy_in;
      end
   end

   assign busy = busy_ff;

endmodule

/* rtl/packet_ring_buffer_manager_core.sv */
// Top level of the packet ring buffer manager: channels, datapath, RAM and sequencer.
//
// Requests arrive on req_chan (valid/ready) and each one produces exactly one response on
// rsp_chan. The block handles one request at a time: ready is high whenever no request is
// in progress, and the request is then run by a microcoded sequencer over a single-port
// 1024 x 8 byte RAM. The RAM port allows one byte access per step, which sets the step
// counts; a claim that meets a padding mark and its wrap costs two extra steps. The
// response is registered and appears the cycle after the last step.
// The response sits in an output register, so a new request can be accepted while an
// earlier response still waits; if the receiver stalls, the next request runs up to its
// final step and holds there until the output register frees up.
// The ring length is written through csr_chan, which is always ready; a write also clears
// the write index, read index and peak occupancy. It must only be issued while idle.
// Reset (synchronous, active high) sets the ring length to 1024 bytes and clears the
// indices and the peak. The RAM contents are not cleared and are undefined until written.
`include "packet_ring_buffer_manager_core_defines.svh"

module packet_ring_buffer_manager_core import prbm_pkg::*; (
   input logic         clock,
   input logic         reset,
   prbm_req_if.sink    req_chan,
   prbm_rsp_if.source  rsp_chan,
   prbm_csr_if.sink    csr_chan
);

   // Ring state.
   logic [IDX_W-1:0]  wr_ff, wr_in;
   logic [IDX_W-1:0]  rd_ff, rd_in;
   logic [PEAK_W-1:0] peak_ff, peak_in;
   logic [RING_W-1:0] ring_ff, ring_in;

   // Latched request fields and working registers.
   logic [LEN_W-1:0]  len_ff;
   logic [OFF_W-1:0]  off_ff;
   logic [BYTE_W-1:0] din_ff;
   logic              flag_ff, flag_in;
   logic [IDX_W-1:0]  nxt_ff, nxt_in;
   logic              status_ff, status_in;
   logic [LEN_W-1:0]  granted_ff, granted_in;
   logic [POFF_W-1:0] poff_ff, poff_in;
   logic [BYTE_W-1:0] dout_ff, dout_in;

   // Output register.
   logic              rsp_valid_ff;
   logic              rsp_status_ff;
   logic [LEN_W-1:0]  rsp_granted_ff;
   logic [POFF_W-1:0] rsp_poff_ff;
   logic [BYTE_W-1:0] rsp_dout_ff;
   logic [PEAK_W-1:0] rsp_peak_ff;

   logic              req_fire, csr_fire, out_free, busy;
   ctl_word_type      cw;
   seq_ctl_type       seq_ctl;
   seq_cond_type      seq_cond;

   logic              ram_we, ram_re;
   logic [MEM_AW-1:0] ram_addr;
   logic [BYTE_W-1:0] ram_wdata, ram_rdata;

   logic [RING_W-1:0] wr_wide, rd_wide;
   logic [RING_W-1:0] csr_ring;

   // Alloc evaluation.
   logic              alloc_bad, alloc_fits, alloc_pad, wr_ge_rd;
   logic [RING_W-1:0] remaining, tail_free, free_sp, avail;
   logic [LEN_W:0]    space;
   logic [LEN_W-1:0]  alloc_grant;
   logic [POFF_W-1:0] alloc_poff;

   // Claim occupancy.
   logic [RING_W-1:0] stored;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign csr_fire = csr_chan.valid && csr_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   assign req_chan.ready = !busy;
   assign csr_chan.ready = 1'b1;

   assign wr_wide = RING_W'(wr_ff);
   assign rd_wide = RING_W'(rd_ff);

   // Ring length is rounded down to a word multiple and held within the usable range.
   always_comb begin
      csr_ring = {csr_chan.ring_bytes[RING_W-1:2], 2'b00};
      if (csr_ring < RING_W'(RING_MIN)) begin
         csr_ring = RING_W'(RING_MIN);
      end else if (csr_ring > RING_W'(RING_MAX)) begin
         csr_ring = RING_W'(RING_MAX);
      end
   end

   prbm_sequencer u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (req_fire),
      .kind     (req_chan.kind),
      .cond     (seq_cond),
      .out_free (out_free),
      .cw       (cw),
      .ctl      (seq_ctl),
      .busy     (busy)
   );

   always_comb begin
      seq_cond.flag     = flag_ff;
      seq_cond.len_nz   = (len_ff != '0);
      seq_cond.rd_eq_wr = (rd_ff == wr_ff);
      seq_cond.is_pad   = (ram_rdata == PAD_MARK);
   end

   // Alloc: the tail piece is used if the request fits there or the head piece is no larger;
   // otherwise a padding mark goes at the write index and the grant comes from the start.
   // A maximum-length request asks for whatever fits, so it only needs a header and one byte.
   always_comb begin
      alloc_bad  = (len_ff == '0) || (len_ff > MAX_PACKET_LEN);
      wr_ge_rd   = (wr_ff >= rd_ff);
      remaining  = ring_ff - wr_wide;
      space      = (len_ff == MAX_PACKET_LEN) ? (LEN_W+1)'(HDR_BYTES + 1)
                                              : {1'b0, len_ff} + (LEN_W+1)'(HDR_BYTES);
      alloc_fits = ((LEN_W+1)'(remaining) >= space);
      tail_free  = (rd_ff != '0) ? remaining : remaining - RING_W'(HDR_BYTES);
      alloc_pad  = wr_ge_rd && !alloc_fits && (rd_wide > remaining);
      if (!wr_ge_rd) begin
         free_sp = rd_wide - wr_wide - RING_W'(1);
      end else if (alloc_pad) begin
         free_sp = rd_wide - RING_W'(HDR_BYTES);
      end else begin
         free_sp = tail_free;
      end
      avail       = (free_sp >= RING_W'(HDR_BYTES)) ? free_sp - RING_W'(HDR_BYTES) : '0;
      alloc_grant = (LEN_W'(avail) < len_ff) ? LEN_W'(avail) : len_ff;
      alloc_poff  = alloc_pad ? POFF_W'(HDR_BYTES) : POFF_W'(wr_wide) + POFF_W'(HDR_BYTES);
   end

   // Bytes between read and write index, for the peak occupancy.
   assign stored = (rd_ff > wr_ff) ? ring_ff - (rd_wide - wr_wide) : wr_wide - rd_wide;

   always_comb begin
      wr_in      = wr_ff;
      rd_in      = rd_ff;
      peak_in    = peak_ff;
      ring_in    = ring_ff;
      flag_in    = flag_ff;
      nxt_in     = nxt_ff;
      status_in  = status_ff;
      granted_in = granted_ff;
      poff_in    = poff_ff;
      dout_in    = dout_ff;
      if (req_fire) begin
         // Fields that a request does not produce read as zero.
         status_in  = 1'b0;
         granted_in = '0;
         poff_in    = '0;
         dout_in    = '0;
      end else if (seq_ctl.exec) begin
         case (cw.action)
            ACT_ALLOC_EVAL: begin
               flag_in = alloc_pad && !alloc_bad;
               if (alloc_bad) begin
                  status_in = 1'b1;
               end else begin
                  granted_in = alloc_grant;
                  poff_in    = alloc_poff;
               end
            end
            ACT_WR_ZERO:   wr_in = '0;
            ACT_WR_NEXT:   wr_in = next_slot(wr_ff, len_ff, ring_ff);
            ACT_PEAK: begin
               if (PEAK_W'(stored) > peak_ff) begin
                  peak_in = PEAK_W'(stored);
               end
            end
            ACT_CLAIM_HDR: begin
               if (ram_rdata == PAD_MARK) begin
                  rd_in = '0;
               end else begin
                  granted_in[LEN_W-1:BYTE_W] = ram_rdata;
               end
            end
            ACT_GRANT_HI:  granted_in[LEN_W-1:BYTE_W] = ram_rdata;
            ACT_GRANT_LO: begin
               granted_in[BYTE_W-1:0] = ram_rdata;
               poff_in = POFF_W'(rd_wide) + POFF_W'(HDR_BYTES);
            end
            ACT_NXT_CALC:  nxt_in = next_slot(rd_ff, len_ff, ring_ff);
            ACT_RD_FREE:   rd_in = (ram_rdata == PAD_MARK) ? '0 : nxt_ff;
            ACT_DOUT:      dout_in = ram_rdata;
            default: begin
            end
         endcase
      end
      if (csr_fire) begin
         ring_in = csr_ring;
         wr_in   = '0;
         rd_in   = '0;
         peak_in = '0;
      end
   end

   always_comb begin
      case (cw.addr_sel)
         ADDR_WR:      ram_addr = MEM_AW'(wr_ff);
         ADDR_WR_NEXT: ram_addr = MEM_AW'(wr_ff) + MEM_AW'(1);
         ADDR_RD:      ram_addr = MEM_AW'(rd_ff);
         ADDR_RD_NEXT: ram_addr = MEM_AW'(rd_ff) + MEM_AW'(1);
         ADDR_OFF:     ram_addr = MEM_AW'(off_ff);
         ADDR_NXT:     ram_addr = MEM_AW'(nxt_ff);
         default:      ram_addr = MEM_AW'(wr_ff);
      endcase
      case (cw.wdata_sel)
         WDATA_PAD:    ram_wdata = PAD_MARK;
         WDATA_LEN_HI: ram_wdata = len_ff[LEN_W-1:BYTE_W];
         WDATA_LEN_LO: ram_wdata = len_ff[BYTE_W-1:0];
         WDATA_DIN:    ram_wdata = din_ff;
         default:      ram_wdata = PAD_MARK;
      endcase
   end

   assign ram_we = seq_ctl.exec && (cw.mem_op == MEM_WRITE);
   assign ram_re = seq_ctl.exec && (cw.mem_op == MEM_READ);

   prbm_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MEM_BYTES)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .re    (ram_re),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff        <= '0;
         rd_ff        <= '0;
         peak_ff      <= '0;
         ring_ff      <= RING_W'(RING_MAX);
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         peak_ff <= peak_in;
         ring_ff <= ring_in;
         if (seq_ctl.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         len_ff <= req_chan.length;
         off_ff <= req_chan.offset;
         din_ff <= req_chan.data_in;
      end
      flag_ff    <= flag_in;
      nxt_ff     <= nxt_in;
      status_ff  <= status_in;
      granted_ff <= granted_in;
      poff_ff    <= poff_in;
      dout_ff    <= dout_in;
      if (seq_ctl.finish) begin
         rsp_status_ff  <= status_in;
         rsp_granted_ff <= granted_in;
         rsp_poff_ff    <= poff_in;
         rsp_dout_ff    <= dout_in;
         rsp_peak_ff    <= peak_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = rsp_status_ff;
   assign rsp_chan.granted_length = rsp_granted_ff;
   assign rsp_chan.packet_offset  = rsp_poff_ff;
   assign rsp_chan.data_out       = rsp_dout_ff;
   assign rsp_chan.peak_occupancy = rsp_peak_ff;

   `PRBM_ASSERT_ALWAYS(a_wr_in_ring, (wr_wide < ring_ff) && (wr_ff[1:0] == 2'b00), "write index off the ring")
   `PRBM_ASSERT_ALWAYS(a_rd_in_ring, (rd_wide < ring_ff) && (rd_ff[1:0] == 2'b00), "read index off the ring")
   `PRBM_ASSERT_ALWAYS(a_peak_bound, PEAK_W'(ring_ff) >= peak_ff, "peak occupancy above ring length")
   `PRBM_ASSERT_ALWAYS(a_ram_busy, !ram_we || busy, "RAM written while no request is in progress")
   `PRBM_ASSERT_NEXT(a_finish_valid, seq_ctl.finish, rsp_valid_ff, "finished request left no response")

endmodule
